// ===== rtl/i2c_trf_pkg.sv =====
// i2c_trf_pkg: shared types, bus phase codes and register addresses for the
// ranging register file I2C target. No dependencies.
`timescale 1ns / 1ps

package i2c_trf_pkg;

  typedef struct packed {
    logic        scl;
    logic        sda;
    logic        ms_tick;
    logic [15:0] distance_mm;
  } sample_t;

  typedef struct packed {
    logic sda_pull_low;
    logic interrupt_pending;
    logic measuring;
  } result_t;

  // register file access requested by the bus side in one beat
  typedef struct packed {
    logic       wr;
    logic [7:0] addr;
    logic [7:0] data;
    logic       start;
    logic       status_clr;
  } bus_req_t;

  localparam logic [3:0] PH_IDLE      = 4'd0;
  localparam logic [3:0] PH_ADDR      = 4'd1;
  localparam logic [3:0] PH_ADDR_ACK  = 4'd2;
  localparam logic [3:0] PH_REG       = 4'd3;
  localparam logic [3:0] PH_REG_ACK   = 4'd4;
  localparam logic [3:0] PH_WDATA     = 4'd5;
  localparam logic [3:0] PH_WDATA_ACK = 4'd6;
  localparam logic [3:0] PH_RDATA     = 4'd7;
  localparam logic [3:0] PH_RDATA_ACK = 4'd8;

  localparam logic [7:0] RG_START    = 8'h00;
  localparam logic [7:0] RG_STATUS   = 8'h13;
  localparam logic [7:0] RG_DIST_HI  = 8'h1E;
  localparam logic [7:0] RG_DIST_LO  = 8'h1F;
  localparam logic [7:0] RG_MODEL_ID = 8'hC0;
  localparam logic [7:0] RG_REV_ID   = 8'hC2;
  localparam logic [7:0] RG_ID_FLAG  = 8'h84;

  localparam logic [7:0] MODEL_ID_VAL = 8'hEE;
  localparam logic [7:0] REV_ID_VAL   = 8'h10;
  localparam logic [7:0] ID_FLAG_VAL  = 8'h01;
  localparam logic [7:0] STATUS_DONE  = 8'h07;
  localparam logic [7:0] START_CMD    = 8'h01;
  localparam logic [15:0] DIST_RESET  = 16'd1000;

  localparam logic [7:0] CFG_OWN_ADDRESS   = 8'd0;
  localparam logic [7:0] CFG_MEASURE_TICKS = 8'd1;

  localparam logic [6:0]  OWN_ADDRESS_RESET   = 7'd41;
  localparam logic [15:0] MEASURE_TICKS_RESET = 16'd75;

  // contents of a register file entry that was never written
  function automatic logic [7:0] reset_byte(input logic [7:0] addr);
    logic [7:0] v;
    case (addr)
      RG_MODEL_ID: v = MODEL_ID_VAL;
      RG_REV_ID:   v = REV_ID_VAL;
      RG_ID_FLAG:  v = ID_FLAG_VAL;
      default:     v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/i2c_trf_meas.sv =====
// i2c_trf_meas: measurement timer, counts millisecond ticks up to the
// programmed length. Depends on i2c_trf_pkg.
`timescale 1ns / 1ps

module i2c_trf_meas
  import i2c_trf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic        ms_tick,
  input  logic [15:0] measure_ticks,
  input  logic        start,
  output logic        done,
  output logic        busy_next
);

  logic        busy;
  logic [15:0] elapsed;
  logic [15:0] elapsed_mid;
  logic [15:0] elapsed_next;
  logic        counting;

  assign counting    = busy && ms_tick;
  // saturating count
  assign elapsed_mid = (elapsed == 16'hFFFF) ? elapsed : 16'(elapsed + 16'd1);
  assign done        = counting && (elapsed_mid >= measure_ticks);

  always_comb begin
    busy_next    = busy;
    elapsed_next = elapsed;
    if (counting) begin
      elapsed_next = elapsed_mid;
    end
    if (done) begin
      busy_next = 1'b0;
    end
    if (start) begin
      busy_next    = 1'b1;
      elapsed_next = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      elapsed <= 16'd0;
    end else if (step) begin
      busy    <= busy_next;
      elapsed <= elapsed_next;
    end
  end

  a_start_restarts: assert property (@(posedge clk) disable iff (rst)
    step && start |=> busy && (elapsed == 16'd0))
    else $error("measurement start did not restart the timer");

endmodule

// ===== rtl/i2c_trf_regs.sv =====
// i2c_trf_regs: register file memory plus the status and distance registers
// that the timer updates. Depends on i2c_trf_pkg.
`timescale 1ns / 1ps

module i2c_trf_regs
  import i2c_trf_pkg::*;
#(
  parameter int REG_COUNT = 256
)
(
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  bus_req_t    req,
  input  logic        done,
  input  logic [15:0] distance_mm,
  input  logic [7:0]  pointer,
  output logic        status_done_mid,
  output logic        irq_next,
  output logic [7:0]  ptr_byte
);

  localparam int AW = $clog2(REG_COUNT);

  logic [7:0]           mem [REG_COUNT];
  logic [REG_COUNT-1:0] vld;
  logic [7:0]           status;
  logic [15:0]          distance;
  logic [7:0]           status_mid;
  logic [7:0]           status_next;
  logic [15:0]          dist_mid;
  logic [15:0]          dist_next;
  logic                 ptr_in_range;
  logic                 wr_in_range;
  logic                 mem_we;
  logic [7:0]           rd_mem;
  logic                 rd_vld;
  logic [7:0]           rd_rst;

  assign status_mid      = done ? STATUS_DONE : status;
  assign dist_mid        = done ? distance_mm : distance;
  assign status_done_mid = (status_mid == STATUS_DONE);

  always_comb begin
    status_next = status_mid;
    dist_next   = dist_mid;
    if (req.wr && req.addr == RG_STATUS) begin
      status_next = req.data;
    end
    if (req.status_clr) begin
      status_next = 8'h00;
    end
    if (req.wr && req.addr == RG_DIST_HI) begin
      dist_next[15:8] = req.data;
    end
    if (req.wr && req.addr == RG_DIST_LO) begin
      dist_next[7:0] = req.data;
    end
  end

  assign irq_next = (status_next == STATUS_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      status   <= 8'h00;
      distance <= DIST_RESET;
    end else if (step) begin
      status   <= status_next;
      distance <= dist_next;
    end
  end

  assign ptr_in_range = ({1'b0, pointer} < 9'(REG_COUNT));
  assign wr_in_range  = ({1'b0, req.addr} < 9'(REG_COUNT));
  assign mem_we       = step && req.wr && wr_in_range;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[req.addr[AW-1:0]] <= req.data;
    end
    rd_mem <= mem[pointer[AW-1:0]];
  end

  // written entries, an unwritten one reads its reset contents
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (mem_we) begin
      vld[req.addr[AW-1:0]] <= 1'b1;
    end
  end

  // registered lookups; pointer is stable before a read byte is shifted out
  always_ff @(posedge clk) begin
    rd_vld <= vld[pointer[AW-1:0]];
    rd_rst <= reset_byte(pointer);
  end

  always_comb begin
    if (!ptr_in_range) begin
      ptr_byte = 8'h00;
    end else if (pointer == RG_STATUS) begin
      ptr_byte = status_next;
    end else if (pointer == RG_DIST_HI) begin
      ptr_byte = dist_next[15:8];
    end else if (pointer == RG_DIST_LO) begin
      ptr_byte = dist_next[7:0];
    end else if (rd_vld) begin
      ptr_byte = rd_mem;
    end else begin
      ptr_byte = rd_rst;
    end
  end

  a_done_sets_status: assert property (@(posedge clk) disable iff (rst)
    step && done && !req.wr && !req.status_clr |=> status == STATUS_DONE)
    else $error("completion did not set status");

  a_start_clears_status: assert property (@(posedge clk) disable iff (rst)
    step && req.start |=> status == 8'h00)
    else $error("measurement start did not clear status");

endmodule

// ===== rtl/i2c_trf_bus.sv =====
// i2c_trf_bus: oversampled I2C target state machine, START/STOP detection,
// address match, pointer and data bytes. Depends on i2c_trf_pkg.
`timescale 1ns / 1ps

module i2c_trf_bus
  import i2c_trf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic       scl,
  input  logic       sda,
  input  logic [6:0] own_address,
  input  logic       status_done_mid,
  input  logic [7:0] ptr_byte,
  output bus_req_t   req,
  output logic [7:0] pointer,
  output logic       pull_low
);

  logic [3:0] phase;
  logic [3:0] phase_next;
  logic [3:0] bit_cnt;
  logic [3:0] bit_cnt_next;
  logic [3:0] bit_cnt_inc;
  logic [7:0] shift_byte;
  logic [7:0] shift_byte_next;
  logic [7:0] pointer_next;
  logic       read_mode;
  logic       read_mode_next;
  logic       scl_last;
  logic       sda_last;
  logic       start_cond;
  logic       stop_cond;
  logic       scl_rise;
  logic       scl_fall;
  logic       rd_bit;

  assign start_cond  = scl && scl_last && sda_last && !sda;
  assign stop_cond   = scl && scl_last && !sda_last && sda;
  assign scl_rise    = !scl_last && scl;
  assign scl_fall    = scl_last && !scl;
  assign bit_cnt_inc = 4'(bit_cnt + 4'd1);

  always_comb begin
    phase_next      = phase;
    bit_cnt_next    = bit_cnt;
    shift_byte_next = shift_byte;
    pointer_next    = pointer;
    read_mode_next  = read_mode;
    req             = '0;
    if (start_cond) begin
      phase_next      = PH_ADDR;
      bit_cnt_next    = 4'd0;
      shift_byte_next = 8'h00;
    end else if (stop_cond) begin
      phase_next = PH_IDLE;
    end else if (scl_rise) begin
      case (phase)
        PH_ADDR, PH_REG, PH_WDATA: begin
          if (!bit_cnt[3]) begin
            shift_byte_next = {shift_byte[6:0], sda};
            bit_cnt_next    = bit_cnt_inc;
          end
        end
        PH_RDATA_ACK: begin
          shift_byte_next = {7'd0, sda};
        end
        default: begin
        end
      endcase
    end else if (scl_fall) begin
      case (phase)
        PH_ADDR: begin
          if (bit_cnt[3]) begin
            if (shift_byte[7:1] == own_address) begin
              read_mode_next = shift_byte[0];
              phase_next     = PH_ADDR_ACK;
            end else begin
              phase_next = PH_IDLE;
            end
          end
        end
        PH_ADDR_ACK: begin
          bit_cnt_next    = 4'd0;
          shift_byte_next = 8'h00;
          phase_next      = read_mode ? PH_RDATA : PH_REG;
        end
        PH_REG: begin
          if (bit_cnt[3]) begin
            pointer_next = shift_byte;
            phase_next   = PH_REG_ACK;
          end
        end
        PH_REG_ACK, PH_WDATA_ACK: begin
          bit_cnt_next    = 4'd0;
          shift_byte_next = 8'h00;
          phase_next      = PH_WDATA;
        end
        PH_WDATA: begin
          if (bit_cnt[3]) begin
            req.wr = 1'b1;
            req.addr = pointer;
            // start command leaves register 0 at zero and clears status
            if (pointer == RG_START && shift_byte == START_CMD) begin
              req.data       = 8'h00;
              req.start      = 1'b1;
              req.status_clr = 1'b1;
            end else begin
              req.data = shift_byte;
            end
            pointer_next = 8'(pointer + 8'd1);
            phase_next   = PH_WDATA_ACK;
          end
        end
        PH_RDATA: begin
          bit_cnt_next = bit_cnt_inc;
          if (bit_cnt_inc[3]) begin
            // reading the completion code clears it
            if (pointer == RG_STATUS && status_done_mid) begin
              req.status_clr = 1'b1;
            end
            pointer_next    = 8'(pointer + 8'd1);
            shift_byte_next = 8'h01;
            phase_next      = PH_RDATA_ACK;
          end
        end
        PH_RDATA_ACK: begin
          if (shift_byte[0]) begin
            phase_next = PH_IDLE;
          end else begin
            bit_cnt_next = 4'd0;
            phase_next   = PH_RDATA;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // pointer does not move in a beat that ends in the read data phase
  assign rd_bit = ptr_byte[3'd7 - bit_cnt_next[2:0]];

  always_comb begin
    case (phase_next)
      PH_ADDR_ACK, PH_REG_ACK, PH_WDATA_ACK: pull_low = 1'b1;
      PH_RDATA:                              pull_low = !rd_bit;
      default:                               pull_low = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      bit_cnt    <= 4'd0;
      shift_byte <= 8'h00;
      pointer    <= 8'h00;
      read_mode  <= 1'b0;
      scl_last   <= 1'b1;
      sda_last   <= 1'b1;
    end else if (step) begin
      phase      <= phase_next;
      bit_cnt    <= bit_cnt_next;
      shift_byte <= shift_byte_next;
      pointer    <= pointer_next;
      read_mode  <= read_mode_next;
      scl_last   <= scl;
      sda_last   <= sda;
    end
  end

  a_pointer_holds: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(pointer))
    else $error("register pointer moved without a line sample");

  a_stop_idles: assert property (@(posedge clk) disable iff (rst)
    step && stop_cond |=> phase == PH_IDLE)
    else $error("stop condition did not return the target to idle");

endmodule

// ===== rtl/i2c_target_ranging_register_file_core.sv =====
// i2c_target_ranging_register_file_core: top level of the ranging register
// file I2C target. Depends on i2c_trf_pkg, i2c_trf_meas, i2c_trf_regs, i2c_trf_bus.
`timescale 1ns / 1ps

// Usage
//   sample channel: one beat per system clock while sample_ready is high
//   carries the sampled SCL and SDA levels, the millisecond tick and the
//   current distance. Each beat is one oversampling step of the bus.
//   result channel: one beat per sample beat with the SDA pull-down request,
//   the interrupt flag (status register holds the completion code) and the
//   measuring flag, all as they stand after that sample.
//   cfg channel: index 0 own_address, index 1 measure_ticks; write only
//   while no result is outstanding. cfg_ready is always high.
// Timing: a result appears in the cycle after its sample beat; one sample
// beat per cycle while the result side does not stall, set by the single
// registered step of the bus state machine and the register file memory with
// one write port and one registered read port.
// Reset (rst, synchronous): bus idle, lines taken as high, timer stopped,
// register file back to its id contents via per-entry valid flags, no
// clearing pass, distance back to its reset value. When the result side
// stalls, sample_ready drops and the result register holds its beat until taken.

module i2c_target_ranging_register_file_core
  import i2c_trf_pkg::*;
#(
  parameter int REG_COUNT = 256
)
(
  input  logic        clk,
  input  logic        rst,
  input  logic        sample_valid,
  output logic        sample_ready,
  input  sample_t     sample,
  output logic        result_valid,
  input  logic        result_ready,
  output result_t     result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [6:0]  own_address;
  logic [15:0] measure_ticks;
  logic        step;
  bus_req_t    req;
  logic        done;
  logic        busy_next;
  logic        status_done_mid;
  logic        irq_next;
  logic [7:0]  ptr_byte;
  logic [7:0]  pointer;
  logic        pull_low;

  assign cfg_ready    = 1'b1;
  assign sample_ready = !rst && (!result_valid || result_ready);
  assign step         = sample_valid && sample_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_address   <= OWN_ADDRESS_RESET;
      measure_ticks <= MEASURE_TICKS_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_OWN_ADDRESS:   own_address   <= cfg_data[6:0];
        CFG_MEASURE_TICKS: measure_ticks <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  i2c_trf_meas u_meas (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .ms_tick       (sample.ms_tick),
    .measure_ticks (measure_ticks),
    .start         (req.start),
    .done          (done),
    .busy_next     (busy_next)
  );

  i2c_trf_regs #(
    .REG_COUNT (REG_COUNT)
  ) u_regs (
    .clk             (clk),
    .rst             (rst),
    .step            (step),
    .req             (req),
    .done            (done),
    .distance_mm     (sample.distance_mm),
    .pointer         (pointer),
    .status_done_mid (status_done_mid),
    .irq_next        (irq_next),
    .ptr_byte        (ptr_byte)
  );

  i2c_trf_bus u_bus (
    .clk             (clk),
    .rst             (rst),
    .step            (step),
    .scl             (sample.scl),
    .sda             (sample.sda),
    .own_address     (own_address),
    .status_done_mid (status_done_mid),
    .ptr_byte        (ptr_byte),
    .req             (req),
    .pointer         (pointer),
    .pull_low        (pull_low)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (step) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result.sda_pull_low      <= pull_low;
      result.interrupt_pending <= irq_next;
      result.measuring         <= busy_next;
    end
  end

  a_step_gives_result: assert property (@(posedge clk) disable iff (rst)
    step |=> result_valid)
    else $error("sample beat produced no result beat");

endmodule
